### rtl/afp_pkg.sv
// Package for the addressed serial frame parser.
// Holds shared constants, register indexes and the structs passed between modules.
// No dependencies.
package afp_pkg;

   // Configuration port
   localparam int unsigned CSR_DATA_W  = 8;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_MARKER   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_MARKER     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 2'd2;

   localparam logic [7:0] START_MARKER_RST   = 8'hAA;
   localparam logic [7:0] END_MARKER_RST     = 8'h55;
   localparam logic [7:0] DEVICE_ADDRESS_RST = 8'h01;

   // Length field width, in range 8 to 16
   localparam int unsigned LENGTH_BITS_DEF = 16;

   // Header byte counter values at which the two length bytes arrive
   localparam logic [2:0] HDR_LEN_HI = 3'd3;
   localparam logic [2:0] HDR_LEN_LO = 3'd4;

   // Stream widths
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 8;
   localparam int unsigned RSP_USER_W = 2;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic [7:0] device_address;
   } afp_cfg_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       payload_last;
      logic       checksum_error;
   } afp_result_type;

endpackage

### rtl/afp_parse_core.sv
// Frame parsing state and the per-byte result logic.
// Depends on afp_pkg for the configuration and result structs.
module afp_parse_core
   import afp_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,   // byte in rx_byte is consumed this cycle
   input  logic [7:0]     rx_byte,
   input  afp_cfg_type    cfg,
   output afp_result_type result
);

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_ADDR  = 3'd1,
      PH_LEN   = 3'd2,
      PH_CHECK = 3'd3,
      PH_END   = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [2:0]             header_count_ff, header_count_in;
   logic [7:0]             running_sum_ff, running_sum_in;
   logic [LENGTH_BITS-1:0] frame_length_ff, frame_length_in;
   logic [LENGTH_BITS-1:0] payload_count_ff, payload_count_in;

   logic [2:0]             header_count_inc;
   logic [7:0]             running_sum_add;
   logic [LENGTH_BITS-1:0] payload_count_inc;
   logic                   abandon;

   assign header_count_inc  = header_count_ff + 3'd1;
   assign running_sum_add   = running_sum_ff + rx_byte;
   assign payload_count_inc = payload_count_ff + LENGTH_BITS'(1);

   // Work out the next parse state and the result for this byte
   always_comb begin
      phase_in         = phase_ff;
      header_count_in  = header_count_ff;
      running_sum_in   = running_sum_ff;
      frame_length_in  = frame_length_ff;
      payload_count_in = payload_count_ff;
      abandon          = 1'b0;
      result           = '0;

      unique case (phase_ff)
         PH_START: begin
            if (rx_byte == cfg.start_marker) begin
               header_count_in = header_count_inc;
               running_sum_in  = running_sum_add;
               phase_in        = PH_ADDR;
            end else begin
               abandon = 1'b1;
            end
         end
         PH_ADDR: begin
            if (rx_byte == cfg.device_address) begin
               header_count_in = header_count_inc;
               running_sum_in  = running_sum_add;
               phase_in        = PH_LEN;
            end else begin
               abandon = 1'b1;
            end
         end
         PH_LEN: begin
            header_count_in = header_count_inc;
            running_sum_in  = running_sum_add;
            priority if (header_count_inc == HDR_LEN_HI) begin
               frame_length_in = LENGTH_BITS'(rx_byte);
            end else if (header_count_inc == HDR_LEN_LO) begin
               frame_length_in = LENGTH_BITS'({frame_length_ff[7:0], rx_byte});
               phase_in        = PH_CHECK;
            end
         end
         PH_CHECK: begin
            if (running_sum_ff == rx_byte) begin
               phase_in = PH_END;
            end else begin
               result.checksum_error = 1'b1;
               abandon               = 1'b1;
            end
         end
         PH_END: begin
            // A zero length closes the frame at the end marker
            if (rx_byte == cfg.end_marker && frame_length_ff != '0) begin
               phase_in = PH_DATA;
            end else begin
               abandon = 1'b1;
            end
         end
         PH_DATA: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = rx_byte;
            payload_count_in     = payload_count_inc;
            if (payload_count_inc == frame_length_ff) begin
               result.payload_last = 1'b1;
               abandon             = 1'b1;
            end
         end
         default: begin
            abandon = 1'b1;
         end
      endcase

      // Drop the frame and wait for a new start marker
      if (abandon) begin
         phase_in         = PH_START;
         header_count_in  = '0;
         running_sum_in   = '0;
         frame_length_in  = '0;
         payload_count_in = '0;
      end
   end

   // Hold parse state; advance once per consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_START;
         header_count_ff  <= '0;
         running_sum_ff   <= '0;
         frame_length_ff  <= '0;
         payload_count_ff <= '0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         header_count_ff  <= header_count_in;
         running_sum_ff   <= running_sum_in;
         frame_length_ff  <= frame_length_in;
         payload_count_ff <= payload_count_in;
      end
   end

endmodule

### rtl/afp_out_reg.sv
// Result register driving the rsp_ stream.
// Depends on afp_pkg for the result struct.
module afp_out_reg
   import afp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,       // new result enters this cycle
   input  afp_result_type result,
   output logic           can_load,   // register is empty or being emptied
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [7:0] payload_byte
   output logic           rsp_tlast,  // payload_last
   output logic [RSP_USER_W-1:0] rsp_tuser   // [0] payload_valid, [1] checksum_error
);

   logic           valid_ff, valid_in;
   afp_result_type data_ff;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // Hold the result until the transaction completes
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff.payload_byte;
   assign rsp_tlast  = data_ff.payload_last;
   assign rsp_tuser  = {data_ff.checksum_error, data_ff.payload_valid};

endmodule

### rtl/addressed_serial_frame_parser.sv
// Top level of the addressed serial frame parser: input register, configuration
// registers, parse core and result register. Depends on afp_pkg, afp_parse_core
// and afp_out_reg.
//
//   channel  direction  transaction                 payload
//   req_     in         req_tvalid & req_tready     tdata[7:0] rx_byte
//   rsp_     out        rsp_tvalid & rsp_tready     tdata[7:0] payload_byte, tlast payload_last,
//                                                   tuser[0] payload_valid, tuser[1] checksum_error
//   csr_     in         csr_we                      csr_index, csr_wdata (write only)
//
// One byte per cycle sustained while rsp_tready stays high; each byte's result goes from the
// input register through the parse logic into the result register, which drives rsp_.
// The parse state updates as a byte moves from the input register into the result register.
// Reset is synchronous: it empties both registers, clears the parse state and loads
// the register defaults.
// With rsp_tready low the result holds, one more byte waits in the input register,
// and req_tready then drops.
module addressed_serial_frame_parser
   import afp_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [7:0] rx_byte
   // Result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] payload_byte
   output logic                   rsp_tlast,   // payload_last
   output logic [RSP_USER_W-1:0]  rsp_tuser,   // [0] payload_valid, [1] checksum_error
   // Configuration
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           can_load;
   logic           advance;
   logic           req_take;
   afp_cfg_type    cfg_ff;
   afp_result_type result;

   assign advance    = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || can_load;
   assign req_take   = req_tvalid && req_tready;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata[7:0];
      end
   end

   // Configuration registers; writes to unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker   <= START_MARKER_RST;
         cfg_ff.end_marker     <= END_MARKER_RST;
         cfg_ff.device_address <= DEVICE_ADDRESS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_MARKER:   cfg_ff.start_marker   <= csr_wdata;
            CSR_END_MARKER:     cfg_ff.end_marker     <= csr_wdata;
            CSR_DEVICE_ADDRESS: cfg_ff.device_address <= csr_wdata;
            default: ;
         endcase
      end
   end

   afp_parse_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   afp_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/afp_checker.sv
// Port-level checks for the addressed serial frame parser, bound to the top level.
// Depends on afp_pkg for the stream widths.
module afp_checker
   import afp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata,
   input logic                   rsp_tlast,
   input logic [RSP_USER_W-1:0]  rsp_tuser
);

   // A stalled result holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Last is only marked on a passed-on payload byte
   a_last_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("last without payload");

   // Non-payload results carry a zero byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("non-payload byte not zero");

   // A checksum error never coincides with payload
   a_cerr_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && !rsp_tlast)
      else $error("checksum error with payload");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind addressed_serial_frame_parser afp_checker u_afp_checker (.*);
